[hdl/hce_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hce_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;
   localparam int OUT_BITS            = 32;

   localparam int PREFIX_LEN = 16;
   localparam logic [4:0] POS_BLANKS = 5'd16;
   localparam logic [4:0] POS_DIGITS = 5'd17;

   localparam logic [7:0] PREFIX_TEXT [PREFIX_LEN] = '{
      8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
      8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
   };

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Phase codes as they appear on the result channel.
   localparam logic [1:0] PHASE_CODE_HEADER = 2'd0;
   localparam logic [1:0] PHASE_CODE_BODY   = 2'd1;
   localparam logic [1:0] PHASE_CODE_DONE   = 2'd2;
   localparam logic [1:0] PHASE_CODE_OVER   = 2'd3;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_BODY   = 4'b0010,
      PH_DONE   = 4'b0100,
      PH_OVER   = 4'b1000
   } phase_type;

   function automatic logic [1:0] phase_code(input phase_type ph);
      logic [1:0] code;
      unique case (ph)
         PH_HEADER: code = PHASE_CODE_HEADER;
         PH_BODY:   code = PHASE_CODE_BODY;
         PH_DONE:   code = PHASE_CODE_DONE;
         PH_OVER:   code = PHASE_CODE_OVER;
         default:   code = PHASE_CODE_HEADER;
      endcase
      return code;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR) ||
             (b == CHAR_VT) || (b == CHAR_FF);
   endfunction

endpackage

`default_nettype wire

[hdl/hce_header.sv]
`timescale 1ns / 1ps
`default_nettype none

module hce_header #(
   parameter int LENGTH_BITS = hce_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [7:0]             data_byte,
   input  wire hce_pkg::phase_type     phase_cur,
   output logic                        header_end,
   output logic [LENGTH_BITS-1:0]      length_cur,
   output logic [LENGTH_BITS-1:0]      length_next
);

   localparam int WIDE_BITS = LENGTH_BITS + 4;

   logic [1:0]             line_pos_ff,       line_pos_in;
   logic                   first_is_cr_ff,    first_is_cr_in;
   logic [4:0]             match_pos_ff,      match_pos_in;
   logic                   match_failed_ff,   match_failed_in;
   logic                   digits_stopped_ff, digits_stopped_in;
   logic [LENGTH_BITS-1:0] digit_accum_ff,    digit_accum_in;
   logic [LENGTH_BITS-1:0] committed_ff,      committed_in;

   logic                   active;
   logic                   is_digit;
   logic [WIDE_BITS-1:0]   accum_wide;
   logic [WIDE_BITS-1:0]   accum_x10;
   logic [LENGTH_BITS-1:0] accum_sat;

   assign active   = step && (phase_cur == hce_pkg::PH_HEADER);
   assign is_digit = (data_byte >= hce_pkg::CHAR_ZERO) && (data_byte <= hce_pkg::CHAR_NINE);

   // Times ten as two shifted adds; any carry into the top nibble means overflow.
   assign accum_wide = {4'b0000, digit_accum_ff};
   assign accum_x10  = (accum_wide << 3) + (accum_wide << 1)
                       + {{(WIDE_BITS-4){1'b0}}, 4'(data_byte - hce_pkg::CHAR_ZERO)};
   assign accum_sat  = (accum_x10[WIDE_BITS-1:LENGTH_BITS] != 4'b0000)
                       ? {LENGTH_BITS{1'b1}} : accum_x10[LENGTH_BITS-1:0];

   always_comb begin
      line_pos_in       = line_pos_ff;
      first_is_cr_in    = first_is_cr_ff;
      match_pos_in      = match_pos_ff;
      match_failed_in   = match_failed_ff;
      digits_stopped_in = digits_stopped_ff;
      digit_accum_in    = digit_accum_ff;
      committed_in      = committed_ff;
      header_end        = 1'b0;

      if (active) begin
         if (data_byte == hce_pkg::CHAR_LF) begin
            if ((line_pos_ff == 2'd1) && first_is_cr_ff) begin
               header_end = 1'b1;
            end else if (!match_failed_ff && (match_pos_ff >= hce_pkg::POS_BLANKS)) begin
               committed_in = digit_accum_ff;
            end
            line_pos_in       = 2'd0;
            first_is_cr_in    = 1'b0;
            match_pos_in      = 5'd0;
            match_failed_in   = 1'b0;
            digits_stopped_in = 1'b0;
            digit_accum_in    = '0;
         end else begin
            if (line_pos_ff == 2'd0) begin
               first_is_cr_in = (data_byte == hce_pkg::CHAR_CR);
            end
            if (line_pos_ff != 2'd2) begin
               line_pos_in = line_pos_ff + 2'd1;
            end
            if (!match_failed_ff && !digits_stopped_ff) begin
               if (match_pos_ff < hce_pkg::POS_BLANKS) begin
                  if (data_byte == hce_pkg::PREFIX_TEXT[match_pos_ff[3:0]]) begin
                     match_pos_in = match_pos_ff + 5'd1;
                  end else begin
                     match_failed_in = 1'b1;
                  end
               end else if (is_digit) begin
                  digit_accum_in = accum_sat;
                  match_pos_in   = hce_pkg::POS_DIGITS;
               end else if (!((match_pos_ff == hce_pkg::POS_BLANKS) &&
                              hce_pkg::is_blank(data_byte))) begin
                  digits_stopped_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pos_ff       <= 2'd0;
         first_is_cr_ff    <= 1'b0;
         match_pos_ff      <= 5'd0;
         match_failed_ff   <= 1'b0;
         digits_stopped_ff <= 1'b0;
         digit_accum_ff    <= '0;
         committed_ff      <= '0;
      end else begin
         line_pos_ff       <= line_pos_in;
         first_is_cr_ff    <= first_is_cr_in;
         match_pos_ff      <= match_pos_in;
         match_failed_ff   <= match_failed_in;
         digits_stopped_ff <= digits_stopped_in;
         digit_accum_ff    <= digit_accum_in;
         committed_ff      <= committed_in;
      end
   end

   assign length_cur  = committed_ff;
   assign length_next = committed_in;

endmodule

`default_nettype wire

[hdl/hce_body.sv]
`timescale 1ns / 1ps
`default_nettype none

module hce_body #(
   parameter int LENGTH_BITS = hce_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic                   header_end,
   input  wire logic [LENGTH_BITS-1:0] length_cur,
   output hce_pkg::phase_type          phase_cur,
   output hce_pkg::phase_type          phase_next,
   output logic                        body_byte,
   output logic [LENGTH_BITS-1:0]      count_next
);

   hce_pkg::phase_type     phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [LENGTH_BITS-1:0] count_inc;

   assign count_inc = (count_ff == {LENGTH_BITS{1'b1}}) ? count_ff
                                                        : count_ff + LENGTH_BITS'(1);

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      body_byte = 1'b0;
      if (step) begin
         unique case (phase_ff) inside
            hce_pkg::PH_HEADER: begin
               if (header_end) begin
                  phase_in = (length_cur == '0) ? hce_pkg::PH_DONE : hce_pkg::PH_BODY;
               end
            end
            hce_pkg::PH_BODY: begin
               body_byte = 1'b1;
               count_in  = count_inc;
               if (count_inc == length_cur) begin
                  phase_in = hce_pkg::PH_DONE;
               end else if (count_inc > length_cur) begin
                  phase_in = hce_pkg::PH_OVER;
               end
            end
            hce_pkg::PH_DONE, hce_pkg::PH_OVER: begin
               phase_in = phase_ff;
            end
            default: begin
               phase_in = hce_pkg::PH_HEADER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hce_pkg::PH_HEADER;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   assign phase_cur  = phase_ff;
   assign phase_next = phase_in;
   assign count_next = count_in;

endmodule

`default_nettype wire

[hdl/http_content_length_extractor.sv]
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_data_byte
// rsp_      out        rsp_valid / rsp_ready  rsp_phase, rsp_header_end, rsp_body_byte,
//                                             rsp_byte_out, rsp_length_value, rsp_body_total
//
// One byte per clock sustained while rsp_ready stays high. A byte is held in the input register,
// then the parser and body counter update from it and load the result register.
// rsp_valid rises when the result register loads, after the byte has passed the input register.
// Synchronous active-high reset returns to the header phase with all counts at zero.
// A stalled result register holds the input register, which in turn drops req_ready.
`timescale 1ns / 1ps
`default_nettype none

module http_content_length_extractor #(
   parameter int LENGTH_BITS = hce_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_phase,
   output logic             rsp_header_end,
   output logic             rsp_body_byte,
   output logic [7:0]       rsp_byte_out,
   output logic [31:0]      rsp_length_value,
   output logic [31:0]      rsp_body_total
);

   localparam int OUT_BITS = hce_pkg::OUT_BITS;

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   out_valid_ff;
   logic [1:0]             out_phase_ff;
   logic                   out_hend_ff;
   logic                   out_body_ff;
   logic [7:0]             out_byte_ff;
   logic [OUT_BITS-1:0]    out_length_ff, out_length_in;
   logic [OUT_BITS-1:0]    out_total_ff,  out_total_in;

   logic                   advance;
   logic                   header_end;
   logic                   body_byte;
   logic [LENGTH_BITS-1:0] length_cur;
   logic [LENGTH_BITS-1:0] length_next;
   logic [LENGTH_BITS-1:0] count_next;
   hce_pkg::phase_type     phase_cur;
   hce_pkg::phase_type     phase_next;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   hce_header #(.LENGTH_BITS(LENGTH_BITS)) u_header (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (in_byte_ff),
      .phase_cur   (phase_cur),
      .header_end  (header_end),
      .length_cur  (length_cur),
      .length_next (length_next)
   );

   hce_body #(.LENGTH_BITS(LENGTH_BITS)) u_body (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .header_end (header_end),
      .length_cur (length_cur),
      .phase_cur  (phase_cur),
      .phase_next (phase_next),
      .body_byte  (body_byte),
      .count_next (count_next)
   );

   // The result fields carry the low bits of the counters.
   generate
      if (LENGTH_BITS >= OUT_BITS) begin : g_trunc
         assign out_length_in = length_next[OUT_BITS-1:0];
         assign out_total_in  = count_next[OUT_BITS-1:0];
      end else begin : g_extend
         assign out_length_in = {{(OUT_BITS-LENGTH_BITS){1'b0}}, length_next};
         assign out_total_in  = {{(OUT_BITS-LENGTH_BITS){1'b0}}, count_next};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance) begin
         out_phase_ff  <= hce_pkg::phase_code(phase_next);
         out_hend_ff   <= header_end;
         out_body_ff   <= body_byte;
         out_byte_ff   <= in_byte_ff;
         out_length_ff <= out_length_in;
         out_total_ff  <= out_total_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_phase        = out_phase_ff;
   assign rsp_header_end   = out_hend_ff;
   assign rsp_body_byte    = out_body_ff;
   assign rsp_byte_out     = out_byte_ff;
   assign rsp_length_value = out_length_ff;
   assign rsp_body_total   = out_total_ff;

`ifndef SYNTHESIS
   a_hend_leaves_header : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_header_end) |->
         (rsp_phase == hce_pkg::PHASE_CODE_BODY || rsp_phase == hce_pkg::PHASE_CODE_DONE))
      else $error("header end reported without leaving the header phase");

   a_body_not_header : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_body_byte) |-> (rsp_phase != hce_pkg::PHASE_CODE_HEADER))
      else $error("body byte counted while still in the header phase");

   a_phase_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_cur))
      else $error("phase register is not one-hot");

   a_done_frozen : assert property (@(posedge clock) disable iff (reset)
      (phase_cur == hce_pkg::PH_DONE || phase_cur == hce_pkg::PH_OVER) |=>
         ($stable(phase_cur) && $stable(length_cur)))
      else $error("state changed after the body finished");
`endif

endmodule

`default_nettype wire
